// ===== hw/rtl/jse_pkg.sv =====
package jse_pkg;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    JOB_CHAR  = 3'd0,
    JOB_SHORT = 3'd1,
    JOB_UESC  = 3'd2,
    JOB_PAIR  = 3'd3,
    JOB_ERR   = 3'd4,
    JOB_ERRQ  = 3'd5
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

endpackage

// ===== hw/rtl/json_string_escaper.sv =====
// JSON string escaper. Send a begin beat, the string bytes as data beats, then an end
// beat; each beat yields zero or more output beats, one character each, and run_last_o
// marks the last character caused by an input beat. status_o flags a UTF-8 error beat
// (character zero); after an error or a NUL in UTF-8 mode, data beats give nothing until
// the next begin or end. Register 0 (utf8_mode, bit 0) selects UTF-8 decoding or byte
// escaping; write it only while the block is idle.
// The first character of a beat is written into the queue and then into the output register.
// Throughput: one output character per cycle while the receiver is ready. A beat that
// produces output yields 1, 2, 6 or 12 characters, so plain text moves at one byte per
// cycle and escapes are paced by the single-character output stage.
// A queue of QueueDepth decoded beats parts the input decoder from the character
// generator; in_ready_o drops only when it is full, so the input keeps flowing while an
// escape drains or the receiver stalls.
// A stalled receiver holds the output register; nothing is lost or repeated.
// Reset clears the decoder, the queue and the output, and sets utf8_mode to 1.
module json_string_escaper #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        run_last_o,
  output logic        status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          utf8_q, utf8_d;
  logic          push, pop, q_full, q_valid;
  jse_pkg::job_t job_in, job_out;

  assign pready = 1'b1;
  assign prdata = {31'h0, utf8_q};

  always_comb begin
    utf8_d = utf8_q;
    if (psel && penable && pwrite && paddr == 2'd0) begin
      utf8_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_q <= 1'b1;
    end else begin
      utf8_q <= utf8_d;
    end
  end

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .utf8_mode_i (utf8_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  jse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .status_o    (status_o)
  );

endmodule

// ===== hw/rtl/jse_front.sv =====
module jse_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             utf8_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       in_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jse_pkg::job_t    job_o
);

  localparam logic [20:0] Min2 = 21'h00080;
  localparam logic [20:0] Min3 = 21'h00800;
  localparam logic [20:0] Min4 = 21'h10000;

  logic [20:0] acc_q, acc_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  seq_q, seq_d;
  logic        skip_q, skip_d;

  logic          has_job;
  jse_pkg::job_t job;
  logic [20:0]   acc_n;
  logic [1:0]    left_n;
  logic [20:0]   minv;
  logic [19:0]   v;
  logic          accept;

  function automatic jse_pkg::job_t unit_job(input logic [15:0] u, input logic raw_high);
    jse_pkg::job_t j;
    logic [7:0]    sh;
    j.kind  = jse_pkg::JOB_UESC;
    j.unit0 = u;
    j.unit1 = '0;
    unique case (u)
      16'h0008: sh = "b";
      16'h0009: sh = "t";
      16'h000A: sh = "n";
      16'h000C: sh = "f";
      16'h000D: sh = "r";
      16'h0022: sh = jse_pkg::ChQuote;
      16'h005C: sh = jse_pkg::ChBslash;
      default:  sh = 8'h00;
    endcase
    if (sh != 8'h00) begin
      j.kind  = jse_pkg::JOB_SHORT;
      j.unit0 = {8'h00, sh};
    end else if (u < 16'h0020) begin
      j.kind = jse_pkg::JOB_UESC;
    end else if (u < 16'h0080 || (raw_high && u < 16'h0100)) begin
      j.kind = jse_pkg::JOB_CHAR;
    end
    return j;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_job;
  assign job_o      = job;

  assign acc_n  = {acc_q[14:0], in_byte_i[5:0]};
  assign left_n = left_q - 2'd1;
  assign v      = 20'(acc_n - Min4);

  always_comb begin
    unique case (seq_q)
      2'd1:    minv = Min2;
      2'd2:    minv = Min3;
      default: minv = Min4;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    left_d  = left_q;
    seq_d   = seq_q;
    skip_d  = skip_q;
    has_job = 1'b0;
    job     = '{kind: jse_pkg::JOB_CHAR, unit0: {8'h00, jse_pkg::ChQuote}, unit1: 16'h0000};
    unique case (cmd_i)
      jse_pkg::CMD_BEGIN: begin
        acc_d   = '0;
        left_d  = '0;
        seq_d   = '0;
        skip_d  = 1'b0;
        has_job = 1'b1;
      end
      jse_pkg::CMD_END: begin
        acc_d   = '0;
        left_d  = '0;
        seq_d   = '0;
        skip_d  = 1'b0;
        has_job = 1'b1;
        if (left_q != 2'd0 && !skip_q) begin
          job.kind = jse_pkg::JOB_ERRQ;
        end
      end
      jse_pkg::CMD_DATA: begin
        if (!skip_q) begin
          if (!utf8_mode_i) begin
            has_job = 1'b1;
            job     = unit_job({8'h00, in_byte_i}, 1'b1);
          end else if (left_q == 2'd0) begin
            if (in_byte_i == 8'h00) begin
              skip_d = 1'b1;
            end else if (in_byte_i < 8'h80) begin
              has_job = 1'b1;
              job     = unit_job({8'h00, in_byte_i}, 1'b0);
            end else if (in_byte_i >= 8'hC2 && in_byte_i <= 8'hDF) begin
              acc_d  = {16'h0000, in_byte_i[4:0]};
              left_d = 2'd1;
              seq_d  = 2'd1;
            end else if (in_byte_i >= 8'hE0 && in_byte_i <= 8'hEF) begin
              acc_d  = {17'h00000, in_byte_i[3:0]};
              left_d = 2'd2;
              seq_d  = 2'd2;
            end else if (in_byte_i >= 8'hF0 && in_byte_i <= 8'hF4) begin
              acc_d  = {18'h00000, in_byte_i[2:0]};
              left_d = 2'd3;
              seq_d  = 2'd3;
            end else begin
              skip_d   = 1'b1;
              has_job  = 1'b1;
              job.kind = jse_pkg::JOB_ERR;
            end
          end else if (in_byte_i[7:6] != 2'b10) begin
            acc_d    = '0;
            left_d   = '0;
            seq_d    = '0;
            skip_d   = 1'b1;
            has_job  = 1'b1;
            job.kind = jse_pkg::JOB_ERR;
          end else if (left_n != 2'd0) begin
            acc_d  = acc_n;
            left_d = left_n;
          end else begin
            acc_d   = '0;
            left_d  = '0;
            seq_d   = '0;
            has_job = 1'b1;
            if (acc_n < minv || (acc_n >= 21'h0D800 && acc_n <= 21'h0DFFF) ||
                acc_n > 21'h10FFFF) begin
              skip_d   = 1'b1;
              job.kind = jse_pkg::JOB_ERR;
            end else if (acc_n > 21'h0FFFF) begin
              job.kind  = jse_pkg::JOB_PAIR;
              job.unit0 = {6'b110110, v[19:10]};
              job.unit1 = {6'b110111, v[9:0]};
            end else begin
              job = unit_job(acc_n[15:0], 1'b0);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
      seq_q  <= '0;
      skip_q <= 1'b0;
    end else if (accept) begin
      acc_q  <= acc_d;
      left_q <= left_d;
      seq_q  <= seq_d;
      skip_q <= skip_d;
    end
  end

endmodule

// ===== hw/rtl/jse_fifo.sv =====
module jse_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jse_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jse_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/jse_back.sv =====
module jse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jse_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          run_last_o,
  output logic          status_o
);

  logic [3:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;
  logic        stat_q, stat_d;

  logic        load;
  logic [3:0]  len;
  logic [15:0] unit;
  logic [2:0]  pos;
  logic [7:0]  esc_char;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  assign load = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    unique case (job_i.kind)
      jse_pkg::JOB_CHAR:  len = 4'd1;
      jse_pkg::JOB_SHORT: len = 4'd2;
      jse_pkg::JOB_UESC:  len = 4'd6;
      jse_pkg::JOB_PAIR:  len = 4'd12;
      jse_pkg::JOB_ERR:   len = 4'd1;
      jse_pkg::JOB_ERRQ:  len = 4'd2;
      default:            len = 4'd1;
    endcase
  end

  always_comb begin
    if (idx_q >= 4'd6) begin
      unit = job_i.unit1;
      pos  = 3'(idx_q - 4'd6);
    end else begin
      unit = job_i.unit0;
      pos  = idx_q[2:0];
    end
    unique case (pos)
      3'd0:    esc_char = jse_pkg::ChBslash;
      3'd1:    esc_char = jse_pkg::ChU;
      3'd2:    esc_char = hex_char(unit[15:12]);
      3'd3:    esc_char = hex_char(unit[11:8]);
      3'd4:    esc_char = hex_char(unit[7:4]);
      3'd5:    esc_char = hex_char(unit[3:0]);
      default: esc_char = 8'h00;
    endcase
  end

  always_comb begin
    char_d = char_q;
    stat_d = stat_q;
    last_d = last_q;
    idx_d  = idx_q;
    pop_o  = 1'b0;
    if (load) begin
      stat_d = 1'b0;
      unique case (job_i.kind)
        jse_pkg::JOB_CHAR:  char_d = job_i.unit0[7:0];
        jse_pkg::JOB_SHORT: char_d = (idx_q == 4'd0) ? jse_pkg::ChBslash : job_i.unit0[7:0];
        jse_pkg::JOB_UESC:  char_d = esc_char;
        jse_pkg::JOB_PAIR:  char_d = esc_char;
        jse_pkg::JOB_ERR: begin
          char_d = 8'h00;
          stat_d = 1'b1;
        end
        jse_pkg::JOB_ERRQ: begin
          char_d = (idx_q == 4'd0) ? 8'h00 : jse_pkg::ChQuote;
          stat_d = (idx_q == 4'd0);
        end
        default: char_d = 8'h00;
      endcase
      last_d = (idx_q == len - 4'd1);
      if (last_d) begin
        idx_d = '0;
        pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    stat_q <= stat_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign run_last_o  = last_q;
  assign status_o    = stat_q;

endmodule

// ===== tb/tb_json_string_escaper.sv =====
`timescale 1ns / 100ps

module tb_json_string_escaper;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       st;
  } lit_char_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] cmd;
    logic [7:0] data;
    logic       typed;
    logic [7:0] ch;
    logic       st;
  } dir_row_t;

  localparam logic [1:0] RegUtf8Mode = 2'd0;
  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam logic       ModeUtf8    = 1'b1;
  localparam logic       ModeByte    = 1'b0;
  localparam logic       StOk        = 1'b0;
  localparam logic       StErr       = 1'b1;
  localparam logic [7:0] NulChar     = 8'h00;
  localparam logic [7:0] ChZero      = "0";
  localparam logic [7:0] ChCapA      = "A";
  localparam logic [7:0] ChLowB      = "b";
  localparam logic [7:0] ChLowT      = "t";
  localparam logic [7:0] ChLowN      = "n";
  localparam logic [7:0] ChLowF      = "f";
  localparam logic [7:0] ChLowR      = "r";
  localparam int         SettleCycles = 16;
  localparam int         SegItems     = 17;

  localparam dir_row_t DirRows [27] = '{
    '{ModeUtf8, jse_pkg::CMD_BEGIN, 8'h00, 1'b1, jse_pkg::ChQuote, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h22, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h5C, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h0A, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h1F, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hC3, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hA9, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hF0, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h9F, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h98, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h80, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hE0, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h80, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h80, 1'b1, NulChar, StErr},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h41, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_BEGIN, 8'h00, 1'b1, jse_pkg::ChQuote, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hC3, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h41, 1'b1, NulChar, StErr},
    '{ModeUtf8, jse_pkg::CMD_BEGIN, 8'h00, 1'b1, jse_pkg::ChQuote, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'hE2, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_END,   8'h00, 1'b0, NulChar, StOk},
    '{ModeUtf8, jse_pkg::CMD_DATA,  8'h00, 1'b0, NulChar, StOk},
    '{ModeUtf8, CmdUnused,          8'hFF, 1'b0, NulChar, StOk},
    '{ModeByte, jse_pkg::CMD_BEGIN, 8'h00, 1'b1, jse_pkg::ChQuote, StOk},
    '{ModeByte, jse_pkg::CMD_DATA,  8'h00, 1'b0, NulChar, StOk},
    '{ModeByte, jse_pkg::CMD_DATA,  8'hFF, 1'b1, 8'hFF,   StOk},
    '{ModeByte, jse_pkg::CMD_END,   8'h00, 1'b1, jse_pkg::ChQuote, StOk}
  };

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i       = jse_pkg::CMD_DATA;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        run_last_o;
  logic        status_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [1:0]  paddr       = 2'd0;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  lit_char_t   lit_chars_q[$];
  lit_char_t   beat_chars[$];
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic [1:0]  seq_cont;
  logic        drop_rest;
  logic        utf8_on;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          items_sent;
  int          mismatches;

  json_string_escaper uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o),
    .status_o   (status_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] hex_ch(input logic [3:0] nib);
    if (nib < 4'd10) return ChZero + {4'h0, nib};
    return ChCapA + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic st);
    lit_char_t c;
    c.ch   = ch;
    c.last = 1'b0;
    c.st   = st;
    beat_chars = {beat_chars, c};
  endfunction

  function automatic void emit_uesc(input logic [15:0] u);
    emit(jse_pkg::ChBslash, StOk);
    emit(jse_pkg::ChU, StOk);
    emit(hex_ch(u[15:12]), StOk);
    emit(hex_ch(u[11:8]), StOk);
    emit(hex_ch(u[7:4]), StOk);
    emit(hex_ch(u[3:0]), StOk);
  endfunction

  function automatic void emit_unit(input logic [15:0] u, input logic raw_high);
    logic [7:0] short_ch;
    short_ch = 8'h00;
    case (u)
      16'h0008: short_ch = ChLowB;
      16'h0009: short_ch = ChLowT;
      16'h000A: short_ch = ChLowN;
      16'h000C: short_ch = ChLowF;
      16'h000D: short_ch = ChLowR;
      16'h0022: short_ch = jse_pkg::ChQuote;
      16'h005C: short_ch = jse_pkg::ChBslash;
      default:  short_ch = 8'h00;
    endcase
    if (short_ch != 8'h00) begin
      emit(jse_pkg::ChBslash, StOk);
      emit(short_ch, StOk);
    end else if (u < 16'h0020) begin
      emit_uesc(u);
    end else if (u < 16'h0080 || (raw_high && u < 16'h0100)) begin
      emit(u[7:0], StOk);
    end else begin
      emit_uesc(u);
    end
  endfunction

  function automatic void clear_decoder();
    cp_acc    = '0;
    cont_left = 2'd0;
    seq_cont  = 2'd0;
  endfunction

  function automatic void raise_error();
    clear_decoder();
    drop_rest = 1'b1;
    emit(NulChar, StErr);
  endfunction

  function automatic void start_seq(input logic [20:0] acc, input logic [1:0] n);
    cp_acc    = acc;
    cont_left = n;
    seq_cont  = n;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [20:0] off;
    if (cont_left == 2'd0) begin
      if (b == 8'h00) drop_rest = 1'b1;
      else if (b < 8'h80) emit_unit({8'h00, b}, 1'b0);
      else if (b >= 8'hC2 && b <= 8'hDF) start_seq({16'h0, b[4:0]}, 2'd1);
      else if (b >= 8'hE0 && b <= 8'hEF) start_seq({17'h0, b[3:0]}, 2'd2);
      else if (b >= 8'hF0 && b <= 8'hF4) start_seq({18'h0, b[2:0]}, 2'd3);
      else raise_error();
    end else if (b[7:6] != 2'b10) begin
      raise_error();
    end else begin
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        cp = cp_acc;
        floor_cp = (seq_cont == 2'd1) ? 21'h80 : (seq_cont == 2'd2) ? 21'h800 : 21'h10000;
        clear_decoder();
        if (cp < floor_cp || (cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF) begin
          raise_error();
        end else if (cp > 21'hFFFF) begin
          off = cp - 21'h10000;
          emit_uesc({6'b110110, off[19:10]});
          emit_uesc({6'b110111, off[9:0]});
        end else begin
          emit_unit(cp[15:0], 1'b0);
        end
      end
    end
  endfunction

  function automatic void escape_beat(input logic [1:0] cmd, input logic [7:0] b);
    beat_chars = {};
    if (cmd == jse_pkg::CMD_BEGIN) begin
      clear_decoder();
      drop_rest = 1'b0;
      emit(jse_pkg::ChQuote, StOk);
    end else if (cmd == jse_pkg::CMD_END) begin
      if (cont_left != 2'd0 && !drop_rest) emit(NulChar, StErr);
      clear_decoder();
      drop_rest = 1'b0;
      emit(jse_pkg::ChQuote, StOk);
    end else if (cmd == jse_pkg::CMD_DATA && !drop_rest) begin
      if (utf8_on) decode_byte(b);
      else emit_unit({8'h00, b}, 1'b1);
    end
    if (beat_chars.size() > 0) begin
      beat_chars[beat_chars.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    lit_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lit_chars_q.size() == 0) begin
        mismatches++;
        $display("%0t: char %h arrived with nothing expected", $time, out_char_o);
      end else begin
        want = lit_chars_q.pop_front();
        if (out_char_o !== want.ch) begin
          mismatches++;
          $display("%0t: out_char expected %h got %h", $time, want.ch, out_char_o);
        end
        if (run_last_o !== want.last) begin
          mismatches++;
          $display("%0t: run_last expected %b got %b", $time, want.last, run_last_o);
        end
        if (status_o !== want.st) begin
          mismatches++;
          $display("%0t: status expected %b got %b", $time, want.st, status_o);
        end
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic typed,
                           input logic [7:0] typed_ch, input logic typed_st);
    lit_char_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    escape_beat(cmd, b);
    if (typed) begin
      c.ch   = typed_ch;
      c.last = 1'b1;
      c.st   = typed_st;
      lit_chars_q = {lit_chars_q, c};
    end else begin
      foreach (beat_chars[i]) lit_chars_q = {lit_chars_q, beat_chars[i]};
    end
  endtask

  task automatic send_data(input logic [7:0] b);
    send_beat(jse_pkg::CMD_DATA, b, 1'b0, NulChar, StOk);
  endtask

  task automatic send_cmd(input logic [1:0] cmd);
    send_beat(cmd, 8'($urandom_range(255)), 1'b0, NulChar, StOk);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (lit_chars_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RegUtf8Mode) utf8_on = val[0];
  endtask

  task automatic send_encoded(input logic [20:0] cp, input int len);
    case (len)
      1: send_data(cp[7:0]);
      2: begin
        send_data({3'b110, cp[10:6]});
        send_data({2'b10, cp[5:0]});
      end
      3: begin
        send_data({4'b1110, cp[15:12]});
        send_data({2'b10, cp[11:6]});
        send_data({2'b10, cp[5:0]});
      end
      default: begin
        send_data({5'b11110, cp[20:18]});
        send_data({2'b10, cp[17:12]});
        send_data({2'b10, cp[11:6]});
        send_data({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic send_random_piece();
    int pick;
    int kind;
    pick = $urandom_range(99);
    kind = $urandom_range(9);
    if (drop_rest && pick < 50) begin
      send_cmd(jse_pkg::CMD_BEGIN);
    end else if (pick < 8) begin
      send_cmd(jse_pkg::CMD_BEGIN);
    end else if (pick < 14) begin
      send_cmd(jse_pkg::CMD_END);
    end else if (pick < 20) begin
      send_data(8'($urandom_range(255)));
    end else if (pick < 24) begin
      send_data(8'($urandom_range(8'hF4, 8'hC2)));
      if ($urandom_range(1) == 0) send_data(8'($urandom_range(8'hBF, 8'h80)));
    end else if (pick < 27) begin
      send_cmd(CmdUnused);
    end else begin
      case (kind)
        2: begin
          if ($urandom_range(1) == 0) send_data(8'($urandom_range(1) ? 8'h22 : 8'h5C));
          else send_data(8'($urandom_range(31, 1)));
        end
        3: send_encoded(21'($urandom_range(21'h7FF, 21'h80)), 2);
        4: send_encoded(21'($urandom_range(21'hFFFF, 21'h800)), 3);
        5: send_encoded(21'($urandom_range(21'h10FFFF, 21'h10000)), 4);
        6: begin
          case ($urandom_range(4))
            0: send_encoded(21'($urandom_range(21'h7F)), 2);
            1: send_encoded(21'($urandom_range(21'h7FF)), 3);
            2: send_encoded(21'($urandom_range(21'hFFFF)), 4);
            3: send_encoded(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
            default: send_encoded(21'($urandom_range(21'h13FFFF, 21'h110000)), 4);
          endcase
        end
        7: begin
          case ($urandom_range(3))
            0: send_encoded(21'h800, 3);
            1: send_encoded(21'hFFFF, 3);
            2: send_encoded(21'hD7FF, 3);
            default: send_encoded(21'hE000, 3);
          endcase
        end
        default: send_data(8'($urandom_range(8'h7E, 8'h20)));
      endcase
    end
  endtask

  initial begin
    int goal;
    clear_decoder();
    drop_rest     = 1'b0;
    utf8_on       = ModeUtf8;
    items_sent    = 0;
    mismatches    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 78;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(RegUtf8Mode, {31'h0, ModeUtf8});

    foreach (DirRows[i]) begin
      if (DirRows[i].mode != utf8_on) begin
        wait_quiet();
        write_reg(RegUtf8Mode, {31'h0, DirRows[i].mode});
      end
      send_beat(DirRows[i].cmd, DirRows[i].data, DirRows[i].typed,
                DirRows[i].ch, DirRows[i].st);
    end

    for (int seg = 0; seg < 6; seg++) begin
      wait_quiet();
      case (seg / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(RegUtf8Mode, {31'h0, (seg % 3 != 1) ? ModeUtf8 : ModeByte});
      goal = items_sent + SegItems;
      while (items_sent < goal) send_random_piece();
    end

    wait_quiet();
    if (mismatches == 0 && lit_chars_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
